@@ sv/ctb_pkg.sv @@
// Shared constants for the Cartesian tree builder: field widths,
// operation codes and status codes.
// No dependencies.
package ctb_pkg;

    // Port field widths
    localparam int NODE_W = 11;
    localparam int PRIO_W = 32;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    // Default node capacity
    localparam int MAX_NODES_DEF = 1024;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

endpackage

@@ sv/cartesian_tree_builder_unit.sv @@
// Cartesian tree builder: node store in one synchronous memory plus a
// small sequencer that walks the right spine and relinks nodes.
// Depends on ctb_pkg.
//
// Usage:
//   Request channel (i_valid / o_stall) carries an operation, a priority
//   and a node index. Result channel (o_valid / i_stall) returns one result
//   per request: node number, parent, left and right links, root, status.
//   Clear, op code 3 and error cases answer 1 cycle after acceptance and a
//   read 2 cycles. An insert into an empty tree takes 2; any other insert
//   takes 3 + k, k being the nodes popped off the right spine (the old root
//   included), plus 1 when a former right subtree must be relinked. Each
//   node is popped at most once over its life, so inserts average a few.
//   One request is in flight at a time. A finished result sits in an output
//   register; while it is stalled, o_stall stays high and no request is taken.
//   Reset (synchronous, active low) empties the tree and drops any pending
//   result. The node memory is not cleared; entries are written before
//   they are read.
module cartesian_tree_builder_unit #(
    parameter int MAX_NODES = ctb_pkg::MAX_NODES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [ctb_pkg::OP_W-1:0]          i_operation,
    input  logic signed [ctb_pkg::PRIO_W-1:0] i_priority_req,
    input  logic [ctb_pkg::NODE_W-1:0]        i_node_index,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [ctb_pkg::NODE_W-1:0]        o_node_number,
    output logic [ctb_pkg::NODE_W-1:0]        o_parent_node,
    output logic [ctb_pkg::NODE_W-1:0]        o_left_node,
    output logic [ctb_pkg::NODE_W-1:0]        o_right_node,
    output logic [ctb_pkg::NODE_W-1:0]        o_root_node,
    output logic [ctb_pkg::STAT_W-1:0]        o_status
);
    import ctb_pkg::*;

    // internal node number width (0 = none), memory address width
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int AW = $clog2(MAX_NODES);
    localparam int XW = (NW > NODE_W) ? NW : NODE_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_ROOT  = 3'd2;
    localparam logic [2:0] S_SUB   = 3'd3;
    localparam logic [2:0] S_WNEW  = 3'd4;
    localparam logic [2:0] S_RDOUT = 3'd5;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [NW-1:0]            par;
        logic [NW-1:0]            lft;
        logic [NW-1:0]            rgt;
    } t_entry;

    // node number to memory address (nodes start at 1)
    function automatic logic [AW-1:0] addr_of(input logic [NW-1:0] node);
        logic [NW-1:0] t;
        t = node - 1'b1;
        return t[AW-1:0];
    endfunction

    // node number to port width (wraps above the port range)
    function automatic logic [NODE_W-1:0] to_port(input logic [NW-1:0] v);
        logic [XW-1:0] t;
        t = XW'(v);
        return t[NODE_W-1:0];
    endfunction

    // node memory
    t_entry r_mem [MAX_NODES];
    t_entry r_rd;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;

    // control and working registers
    logic [2:0]               r_state, n_state;
    logic [NW-1:0]            r_root, n_root;
    logic [NW-1:0]            r_last, n_last;
    logic [NW-1:0]            r_count, n_count;
    logic signed [PRIO_W-1:0] r_pri, n_pri;
    logic [NW-1:0]            r_new, n_new;
    logic [NW-1:0]            r_walk, n_walk;
    logic [NW-1:0]            r_par, n_par;
    logic [NW-1:0]            r_lft, n_lft;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [NODE_W-1:0]   r_out_node, n_out_node;
    logic [NODE_W-1:0]   r_out_par, n_out_par;
    logic [NODE_W-1:0]   r_out_lft, n_out_lft;
    logic [NODE_W-1:0]   r_out_rgt, n_out_rgt;
    logic [NODE_W-1:0]   r_out_root, n_out_root;
    logic [STAT_W-1:0]   r_out_stat, n_out_stat;
    logic                load_out;

    logic          out_free;
    logic          accept;
    logic [XW-1:0] idx_ext;
    logic [XW-1:0] count_ext;
    logic [NW-1:0] new_root;

    assign out_free  = !r_out_valid || !i_stall;
    assign o_stall   = (r_state != S_IDLE) || !out_free;
    assign accept    = i_valid && !o_stall;
    assign idx_ext   = XW'(i_node_index);
    assign count_ext = XW'(r_count);
    assign new_root  = (r_par == '0) ? r_new : r_root;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_root     = r_root;
        n_last     = r_last;
        n_count    = r_count;
        n_pri      = r_pri;
        n_new      = r_new;
        n_walk     = r_walk;
        n_par      = r_par;
        n_lft      = r_lft;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = r_rd;
        load_out   = 1'b0;
        n_out_node = '0;
        n_out_par  = '0;
        n_out_lft  = '0;
        n_out_rgt  = '0;
        n_out_root = to_port(r_root);
        n_out_stat = ST_OK;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        OP_CLEAR: begin
                            n_root     = '0;
                            n_last     = '0;
                            n_count    = '0;
                            load_out   = 1'b1;
                            n_out_root = '0;
                        end
                        OP_INSERT: begin
                            if (r_count >= NW'(MAX_NODES)) begin
                                load_out   = 1'b1;
                                n_out_stat = ST_FULL;
                            end else begin
                                n_new = r_count + 1'b1;
                                n_pri = i_priority_req;
                                n_par = '0;
                                n_lft = '0;
                                if (r_root == '0) begin
                                    n_state = S_WNEW;
                                end else begin
                                    // start the spine walk at the last node
                                    mem_re    = 1'b1;
                                    mem_raddr = addr_of(r_last);
                                    n_walk    = r_last;
                                    n_state   = S_WALK;
                                end
                            end
                        end
                        OP_READ: begin
                            if (i_node_index == '0 || idx_ext > count_ext) begin
                                load_out   = 1'b1;
                                n_out_stat = ST_RANGE;
                            end else begin
                                n_walk    = NW'(idx_ext);
                                mem_re    = 1'b1;
                                mem_raddr = addr_of(NW'(idx_ext));
                                n_state   = S_RDOUT;
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_pri < r_rd.prio) begin
                    // pop: climb to the parent, or past the root
                    if (r_rd.par == '0) begin
                        mem_re    = 1'b1;
                        mem_raddr = addr_of(r_root);
                        n_state   = S_ROOT;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = addr_of(r_rd.par);
                        n_walk    = r_rd.par;
                    end
                end else begin
                    // stop: new node becomes right child of this one
                    mem_we        = 1'b1;
                    mem_waddr     = addr_of(r_walk);
                    mem_wdata     = r_rd;
                    mem_wdata.rgt = r_new;
                    n_par         = r_walk;
                    n_lft         = r_rd.rgt;
                    if (r_rd.rgt != '0) begin
                        mem_re    = 1'b1;
                        mem_raddr = addr_of(r_rd.rgt);
                        n_walk    = r_rd.rgt;
                        n_state   = S_SUB;
                    end else begin
                        n_state = S_WNEW;
                    end
                end
            end
            S_ROOT: begin
                // old root hangs below the new node
                mem_we        = 1'b1;
                mem_waddr     = addr_of(r_root);
                mem_wdata     = r_rd;
                mem_wdata.par = r_new;
                n_par         = '0;
                n_lft         = r_root;
                n_state       = S_WNEW;
            end
            S_SUB: begin
                // former right subtree moves under the new node
                mem_we        = 1'b1;
                mem_waddr     = addr_of(r_walk);
                mem_wdata     = r_rd;
                mem_wdata.par = r_new;
                n_state       = S_WNEW;
            end
            S_WNEW: begin
                if (out_free) begin
                    mem_we         = 1'b1;
                    mem_waddr      = addr_of(r_new);
                    mem_wdata.prio = r_pri;
                    mem_wdata.par  = r_par;
                    mem_wdata.lft  = r_lft;
                    mem_wdata.rgt  = '0;
                    n_last         = r_new;
                    n_count        = r_new;
                    n_root         = new_root;
                    load_out       = 1'b1;
                    n_out_node     = to_port(r_new);
                    n_out_par      = to_port(r_par);
                    n_out_lft      = to_port(r_lft);
                    n_out_root     = to_port(new_root);
                    n_state        = S_IDLE;
                end
            end
            S_RDOUT: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    n_out_node = to_port(r_walk);
                    n_out_par  = to_port(r_rd.par);
                    n_out_lft  = to_port(r_rd.lft);
                    n_out_rgt  = to_port(r_rd.rgt);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // output valid: set on a new result, cleared when taken
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // node memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_root      <= '0;
            r_last      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_root      <= n_root;
            r_last      <= n_last;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // working and result payload registers
    always_ff @(posedge i_clk) begin
        r_pri  <= n_pri;
        r_new  <= n_new;
        r_walk <= n_walk;
        r_par  <= n_par;
        r_lft  <= n_lft;
        if (load_out) begin
            r_out_node <= n_out_node;
            r_out_par  <= n_out_par;
            r_out_lft  <= n_out_lft;
            r_out_rgt  <= n_out_rgt;
            r_out_root <= n_out_root;
            r_out_stat <= n_out_stat;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_node_number = r_out_node;
    assign o_parent_node = r_out_par;
    assign o_left_node   = r_out_lft;
    assign o_right_node  = r_out_rgt;
    assign o_root_node   = r_out_root;
    assign o_status      = r_out_stat;

endmodule
